>>> sv/hpc_pkg.sv
// Shared types and constants for the hex point-to-cell converter.
package hpc_pkg;

    // Configuration request channel widths
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 32;

    // Register indexes of the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ORIENTATION = 8'd0,
        REG_X_RECIP     = 8'd1,
        REG_Y_RECIP     = 8'd2,
        REG_BOUNDED     = 8'd3,
        REG_MIN_Q       = 8'd4,
        REG_MIN_R       = 8'd5,
        REG_MAX_Q       = 8'd6,
        REG_MAX_R       = 8'd7
    } cfg_reg_t;

    // Orientation codes
    localparam logic ORIENT_FLAT   = 1'b0;
    localparam logic ORIENT_POINTY = 1'b1;

    // Reset values of the configuration registers
    localparam logic [31:0] X_RECIP_RESET = 32'd22369621;
    localparam logic [31:0] Y_RECIP_RESET = 32'd16777216;

    // Datapath widths
    localparam int unsigned POS_W   = 32;  // Q16.16 input coordinate
    localparam int unsigned PROD_W  = 64;  // coordinate times reciprocal, Q.40
    localparam int unsigned P32_W   = 56;  // product floored to Q.32
    localparam int unsigned EST_W   = 60;  // fractional estimates in Q.33
    localparam int unsigned CELL_W  = 28;  // full-width integer cell coordinate
    localparam int unsigned ERR_W   = 62;  // rounding error in Q.33
    localparam int unsigned COORD_W = 16;  // saturated output coordinate

    // Payload types
    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [P32_W-1:0]   p32_t;
    typedef logic signed [EST_W-1:0]   est_t;
    typedef logic signed [CELL_W-1:0]  cell_t;
    typedef logic        [ERR_W-1:0]   err_t;
    typedef logic signed [COORD_W-1:0] coord_t;

endpackage

>>> sv/hpc_if.sv
// Valid/ready channel interfaces for points, cells and configuration requests.
interface hpc_point_if;
    logic               valid;
    logic               ready;
    hpc_pkg::pos_t      pos_x;
    hpc_pkg::pos_t      pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface hpc_cell_if;
    logic               valid;
    logic               ready;
    logic               found;
    hpc_pkg::coord_t    cell_q;
    hpc_pkg::coord_t    cell_r;

    modport source (output valid, output found, output cell_q, output cell_r, input ready);
    modport sink   (input valid, input found, input cell_q, input cell_r, output ready);
endinterface

interface hpc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [hpc_pkg::CFG_INDEX_W-1:0]     index;
    logic [hpc_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/hex_point_to_cell.sv
// Hex point-to-cell converter: five-stage pipeline from Q16.16 point to axial cell.
// Throughput: one point per cycle while the output is not stalled; the two 32x33
// reciprocal multipliers in stage 1 and the Q.33 error compare in stage 4 set the stage depth.
// A stall at the output holds every stage; nothing is dropped or repeated.
// Reset clears all stage valid bits and loads the register defaults.
module hex_point_to_cell
(
    input  logic         clk,
    input  logic         rst_n,
    hpc_point_if.sink    req,
    hpc_cell_if.source   rsp,
    hpc_cfg_if.sink      cfg
);

    // Configuration registers
    logic                  orientation_reg;
    logic [31:0]           x_recip_reg;
    logic [31:0]           y_recip_reg;
    logic                  bounded_reg;
    hpc_pkg::coord_t       min_q_reg;
    hpc_pkg::coord_t       min_r_reg;
    hpc_pkg::coord_t       max_q_reg;
    hpc_pkg::coord_t       max_r_reg;

    // Pipeline control
    logic                  advance;
    logic                  s1_valid_reg;
    logic                  s2_valid_reg;
    logic                  s3_valid_reg;
    logic                  s4_valid_reg;
    logic                  s5_valid_reg;

    // Stage 1: floored products
    logic signed [64:0]    mul_x;
    logic signed [64:0]    mul_y;
    hpc_pkg::p32_t         prx_reg;
    hpc_pkg::p32_t         pry_reg;

    // Stage 2: fractional estimates
    hpc_pkg::est_t         prx_ext;
    hpc_pkg::est_t         pry_ext;
    hpc_pkg::est_t         qf_next;
    hpc_pkg::est_t         rf_next;
    hpc_pkg::est_t         qf_reg;
    hpc_pkg::est_t         rf_reg;
    hpc_pkg::est_t         yf_reg;

    // Stage 3: rounded components
    hpc_pkg::est_t         qf3_reg;
    hpc_pkg::est_t         rf3_reg;
    hpc_pkg::est_t         yf3_reg;
    hpc_pkg::cell_t        rx_reg;
    hpc_pkg::cell_t        ry_reg;
    hpc_pkg::cell_t        rz_reg;

    // Stage 4: rebuilt cell
    hpc_pkg::err_t         dx;
    hpc_pkg::err_t         dy;
    hpc_pkg::err_t         dz;
    hpc_pkg::cell_t        cq_next;
    hpc_pkg::cell_t        cr_next;
    hpc_pkg::cell_t        cq_reg;
    hpc_pkg::cell_t        cr_reg;

    // Stage 5: bounds and saturation
    logic                  found_next;
    hpc_pkg::coord_t       sat_q;
    hpc_pkg::coord_t       sat_r;
    logic                  found_reg;
    hpc_pkg::coord_t       cell_q_reg;
    hpc_pkg::coord_t       cell_r_reg;

    // Round a Q.33 value to an integer, ties away from zero
    function automatic hpc_pkg::cell_t round33(input hpc_pkg::est_t v);
        logic [hpc_pkg::EST_W-1:0] mag;
        logic [hpc_pkg::EST_W-1:0] t;
        mag = v[hpc_pkg::EST_W-1] ? hpc_pkg::EST_W'(-v) : hpc_pkg::EST_W'(v);
        t   = (mag + (hpc_pkg::EST_W'(1) << 32)) >> 33;
        return v[hpc_pkg::EST_W-1] ? -$signed(t[hpc_pkg::CELL_W-1:0])
                                   : $signed(t[hpc_pkg::CELL_W-1:0]);
    endfunction

    // Absolute rounding error |n - v| in Q.33
    function automatic hpc_pkg::err_t err33(input hpc_pkg::cell_t n, input hpc_pkg::est_t v);
        logic signed [hpc_pkg::ERR_W-1:0] d;
        d = $signed({{(hpc_pkg::ERR_W-hpc_pkg::CELL_W-33){n[hpc_pkg::CELL_W-1]}}, n, 33'd0})
            - $signed({{(hpc_pkg::ERR_W-hpc_pkg::EST_W){v[hpc_pkg::EST_W-1]}}, v});
        return d[hpc_pkg::ERR_W-1] ? hpc_pkg::err_t'(-d) : hpc_pkg::err_t'(d);
    endfunction

    // Saturate a full-width cell coordinate to 16 bits
    function automatic hpc_pkg::coord_t sat16(input hpc_pkg::cell_t v);
        if (v > hpc_pkg::cell_t'(32767))
        begin
            return 16'sh7FFF;
        end
        else if (v < -hpc_pkg::cell_t'(32768))
        begin
            return 16'sh8000;
        end
        return v[hpc_pkg::COORD_W-1:0];
    endfunction

    // Sign-extend a limit to the full cell width
    function automatic hpc_pkg::cell_t ext16(input hpc_pkg::coord_t v);
        return {{(hpc_pkg::CELL_W-hpc_pkg::COORD_W){v[hpc_pkg::COORD_W-1]}}, v};
    endfunction

    // Write configuration registers; requests are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg <= hpc_pkg::ORIENT_FLAT;
            x_recip_reg     <= hpc_pkg::X_RECIP_RESET;
            y_recip_reg     <= hpc_pkg::Y_RECIP_RESET;
            bounded_reg     <= 1'b0;
            min_q_reg       <= '0;
            min_r_reg       <= '0;
            max_q_reg       <= '0;
            max_r_reg       <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                hpc_pkg::REG_ORIENTATION: orientation_reg <= cfg.data[0];
                hpc_pkg::REG_X_RECIP:     x_recip_reg     <= cfg.data;
                hpc_pkg::REG_Y_RECIP:     y_recip_reg     <= cfg.data;
                hpc_pkg::REG_BOUNDED:     bounded_reg     <= cfg.data[0];
                hpc_pkg::REG_MIN_Q:       min_q_reg       <= cfg.data[15:0];
                hpc_pkg::REG_MIN_R:       min_r_reg       <= cfg.data[15:0];
                hpc_pkg::REG_MAX_Q:       max_q_reg       <= cfg.data[15:0];
                hpc_pkg::REG_MAX_R:       max_r_reg       <= cfg.data[15:0];
                default:                  ;
            endcase
        end
    end

    // Advance the whole pipeline unless the output register is held
    assign advance   = !s5_valid_reg || rsp.ready;
    assign req.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 1: multiply by the reciprocals, floor Q.40 to Q.32
    assign mul_x = req.pos_x * $signed({1'b0, x_recip_reg});
    assign mul_y = req.pos_y * $signed({1'b0, y_recip_reg});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prx_reg <= mul_x[hpc_pkg::PROD_W-1:8];
            pry_reg <= mul_y[hpc_pkg::PROD_W-1:8];
        end
    end

    // Stage 2: form major and minor estimates and the third cube component
    assign prx_ext = {{(hpc_pkg::EST_W-hpc_pkg::P32_W){prx_reg[hpc_pkg::P32_W-1]}}, prx_reg};
    assign pry_ext = {{(hpc_pkg::EST_W-hpc_pkg::P32_W){pry_reg[hpc_pkg::P32_W-1]}}, pry_reg};

    always_comb
    begin
        if (orientation_reg == hpc_pkg::ORIENT_FLAT)
        begin
            qf_next = prx_ext <<< 1;
            rf_next = (pry_ext <<< 1) - prx_ext;
        end
        else
        begin
            qf_next = (prx_ext <<< 1) - pry_ext;
            rf_next = pry_ext <<< 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            qf_reg <= qf_next;
            rf_reg <= rf_next;
            yf_reg <= -qf_next - rf_next;
        end
    end

    // Stage 3: round each component
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            qf3_reg <= qf_reg;
            rf3_reg <= rf_reg;
            yf3_reg <= yf_reg;
            rx_reg  <= round33(qf_reg);
            ry_reg  <= round33(yf_reg);
            rz_reg  <= round33(rf_reg);
        end
    end

    // Stage 4: rebuild the component with the largest rounding error
    assign dx = err33(rx_reg, qf3_reg);
    assign dy = err33(ry_reg, yf3_reg);
    assign dz = err33(rz_reg, rf3_reg);

    always_comb
    begin
        cq_next = rx_reg;
        cr_next = rz_reg;
        if (dx > dy && dx > dz)
        begin
            cq_next = -ry_reg - rz_reg;
        end
        else if (dy <= dz)
        begin
            cr_next = -rx_reg - ry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            cq_reg <= cq_next;
            cr_reg <= cr_next;
        end
    end

    // Stage 5: check limits on full width, saturate, zero when out of bounds
    assign found_next = !bounded_reg ||
                        (cq_reg >= ext16(min_q_reg) && cq_reg <= ext16(max_q_reg) &&
                         cr_reg >= ext16(min_r_reg) && cr_reg <= ext16(max_r_reg));
    assign sat_q = sat16(cq_reg);
    assign sat_r = sat16(cr_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            found_reg  <= found_next;
            cell_q_reg <= found_next ? sat_q : '0;
            cell_r_reg <= found_next ? sat_r : '0;
        end
    end

    // Drive the result channel from the output register
    assign rsp.valid  = s5_valid_reg;
    assign rsp.found  = found_reg;
    assign rsp.cell_q = cell_q_reg;
    assign rsp.cell_r = cell_r_reg;

endmodule

>>> bench/tb.sv
// Self-checking testbench for the hex point-to-cell converter.
`timescale 1ns / 100ps

module tb;

    // Spare register index that the block must ignore
    localparam logic [hpc_pkg::CFG_INDEX_W-1:0] REG_SPARE_INDEX = 8'd200;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam logic [31:0] RECIP_ONE = 32'h0100_0000;

    typedef struct packed {
        hpc_pkg::pos_t pos_x;
        hpc_pkg::pos_t pos_y;
    } point_t;

    typedef struct packed {
        logic            found;
        hpc_pkg::coord_t cell_q;
        hpc_pkg::coord_t cell_r;
    } cell_rsp_t;

    typedef struct {
        logic [hpc_pkg::CFG_INDEX_W-1:0] index;
        logic [hpc_pkg::CFG_DATA_W-1:0]  data;
    } reg_write_t;

    typedef logic signed [79:0] wide_t;

    logic clk = 1'b0;
    logic rst_n;

    hpc_point_if point_ch();
    hpc_cell_if  cell_ch();
    hpc_cfg_if   cfg_ch();

    hex_point_to_cell DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (point_ch),
        .rsp   (cell_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the configuration registers
    logic            cur_orient;
    logic [31:0]     cur_x_recip;
    logic [31:0]     cur_y_recip;
    logic            cur_bounded;
    hpc_pkg::coord_t cur_min_q;
    hpc_pkg::coord_t cur_min_r;
    hpc_pkg::coord_t cur_max_q;
    hpc_pkg::coord_t cur_max_r;

    point_t      pending_points[$];
    cell_rsp_t   expected_cells[$];
    reg_write_t  pending_writes[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned points_accepted = 0;
    int unsigned cells_checked = 0;
    int unsigned outside_count = 0;
    int unsigned saturated_count = 0;
    int unsigned reg_writes_done = 0;
    int unsigned stall_cycles = 0;

    // Clock: 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Coordinate times reciprocal, Q.40 floored to Q.32
    function automatic wide_t scale_floor(hpc_pkg::pos_t c, logic [31:0] recip);
        wide_t prod;
        prod = wide_t'(c) * $signed({48'd0, recip});
        return prod >>> 8;
    endfunction

    // Q.33 to nearest integer, ties away from zero
    function automatic wide_t round_half_away(wide_t v);
        wide_t half;
        half = wide_t'(1) <<< 32;
        if (v >= 0)
            return (v + half) >>> 33;
        return -((-v + half) >>> 33);
    endfunction

    function automatic wide_t round_error(wide_t n, wide_t v);
        wide_t d;
        d = (n <<< 33) - v;
        return (d < 0) ? -d : d;
    endfunction

    function automatic hpc_pkg::coord_t clamp16(wide_t v);
        if (v > wide_t'(32767))
            return 16'sh7fff;
        if (v < wide_t'(-32768))
            return 16'sh8000;
        return v[15:0];
    endfunction

    // Expected cell for one point under the current register settings
    function automatic cell_rsp_t locate_cell(hpc_pkg::pos_t px, hpc_pkg::pos_t py);
        wide_t     pmx, pmy, qf, rf, yf;
        wide_t     cq, cy, cr, eq, ey, er;
        cell_rsp_t res;
        pmx = scale_floor(px, cur_x_recip);
        pmy = scale_floor(py, cur_y_recip);
        if (cur_orient == hpc_pkg::ORIENT_FLAT)
        begin
            qf = pmx + pmx;
            rf = pmy + pmy - pmx;
        end
        else
        begin
            rf = pmy + pmy;
            qf = pmx + pmx - pmy;
        end
        yf = -qf - rf;
        cq = round_half_away(qf);
        cy = round_half_away(yf);
        cr = round_half_away(rf);
        eq = round_error(cq, qf);
        ey = round_error(cy, yf);
        er = round_error(cr, rf);
        // rebuild the component that rounded worst
        if (eq > ey && eq > er)
            cq = -cy - cr;
        else if (ey > er)
            cy = -cq - cr;
        else
            cr = -cq - cy;
        res.found = 1'b1;
        if (cur_bounded && (cq < cur_min_q || cq > cur_max_q ||
                            cr < cur_min_r || cr > cur_max_r))
            res.found = 1'b0;
        res.cell_q = res.found ? clamp16(cq) : '0;
        res.cell_r = res.found ? clamp16(cr) : '0;
        return res;
    endfunction

    // Configuration driver: apply accepted writes to the shadow, present the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cur_orient   <= hpc_pkg::ORIENT_FLAT;
            cur_x_recip  <= hpc_pkg::X_RECIP_RESET;
            cur_y_recip  <= hpc_pkg::Y_RECIP_RESET;
            cur_bounded  <= 1'b0;
            cur_min_q    <= '0;
            cur_min_r    <= '0;
            cur_max_q    <= '0;
            cur_max_r    <= '0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    hpc_pkg::REG_ORIENTATION: cur_orient  <= cfg_ch.data[0];
                    hpc_pkg::REG_X_RECIP:     cur_x_recip <= cfg_ch.data;
                    hpc_pkg::REG_Y_RECIP:     cur_y_recip <= cfg_ch.data;
                    hpc_pkg::REG_BOUNDED:     cur_bounded <= cfg_ch.data[0];
                    hpc_pkg::REG_MIN_Q:       cur_min_q   <= cfg_ch.data[15:0];
                    hpc_pkg::REG_MIN_R:       cur_min_r   <= cfg_ch.data[15:0];
                    hpc_pkg::REG_MAX_Q:       cur_max_q   <= cfg_ch.data[15:0];
                    hpc_pkg::REG_MAX_R:       cur_max_r   <= cfg_ch.data[15:0];
                    default: ;
                endcase
                void'(pending_writes.pop_front());
                reg_writes_done++;
            end
            if (pending_writes.size() != 0)
            begin
                cfg_ch.valid <= 1'b1;
                cfg_ch.index <= pending_writes[0].index;
                cfg_ch.data  <= pending_writes[0].data;
            end
            else
                cfg_ch.valid <= 1'b0;
        end
    end

    // Point driver: predict on acceptance, hold a stalled request, idle at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_ch.valid <= 1'b0;
        else
        begin
            if (point_ch.valid && point_ch.ready)
            begin
                expected_cells.push_back(locate_cell(point_ch.pos_x, point_ch.pos_y));
                void'(pending_points.pop_front());
                points_accepted++;
            end
            if (!point_ch.valid || point_ch.ready)
            begin
                if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    point_ch.valid <= 1'b1;
                    point_ch.pos_x <= pending_points[0].pos_x;
                    point_ch.pos_y <= pending_points[0].pos_y;
                end
                else
                    point_ch.valid <= 1'b0;
            end
        end
    end

    // Cell monitor: compare each accepted cell with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        cell_rsp_t want;
        if (!rst_n)
            cell_ch.ready <= 1'b0;
        else
        begin
            if (cell_ch.valid && cell_ch.ready)
            begin
                cells_checked++;
                if (!cell_ch.found)
                    outside_count++;
                else if (cell_ch.cell_q == 16'sh7fff || cell_ch.cell_q == 16'sh8000 ||
                         cell_ch.cell_r == 16'sh7fff || cell_ch.cell_r == 16'sh8000)
                    saturated_count++;
                if (expected_cells.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected cell found=%0b q=%0d r=%0d", $realtime,
                                 cell_ch.found, cell_ch.cell_q, cell_ch.cell_r);
                end
                else
                begin
                    want = expected_cells.pop_front();
                    if (cell_ch.found !== want.found || cell_ch.cell_q !== want.cell_q ||
                        cell_ch.cell_r !== want.cell_r)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: cell mismatch, expected %0b %0d %0d, got %0b %0d %0d",
                                     $realtime, want.found, want.cell_q, want.cell_r,
                                     cell_ch.found, cell_ch.cell_q, cell_ch.cell_r);
                    end
                end
            end
            cell_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run when no request moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((point_ch.valid && point_ch.ready) || (cell_ch.valid && cell_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog expired after %0d idle cycles", stall_cycles);
                $display("Some tests failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic set_reg(logic [hpc_pkg::CFG_INDEX_W-1:0] idx, logic [31:0] val);
        reg_write_t w;
        w.index = idx;
        w.data  = val;
        pending_writes.push_back(w);
    endtask

    // Wait until every queued register write has been taken
    task automatic settle_config();
        while (pending_writes.size() != 0 || cfg_ch.valid)
            @(negedge clk);
    endtask

    // Wait until all points are taken and every predicted cell has come back
    task automatic drain();
        while (pending_points.size() != 0 || point_ch.valid || expected_cells.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_point(hpc_pkg::pos_t px, hpc_pkg::pos_t py);
        point_t p;
        p.pos_x = px;
        p.pos_y = py;
        pending_points.push_back(p);
    endtask

    // Mostly near the origin, some on a quarter-unit grid to force ties, some anywhere, some at the extreme values
    function automatic hpc_pkg::pos_t pick_coord();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return hpc_pkg::pos_t'(int'($urandom_range(33554431)) - 16777216);
        if (sel < 80)
            return hpc_pkg::pos_t'((int'($urandom_range(64)) - 32) * 16384);
        if (sel < 95)
            return hpc_pkg::pos_t'($urandom);
        case ($urandom_range(4))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    task automatic add_random(int unsigned n);
        repeat (n)
            add_point(pick_coord(), pick_coord());
    endtask

    task automatic set_limits(int lo_q, int lo_r, int hi_q, int hi_r);
        set_reg(hpc_pkg::REG_MIN_Q, lo_q);
        set_reg(hpc_pkg::REG_MIN_R, lo_r);
        set_reg(hpc_pkg::REG_MAX_Q, hi_q);
        set_reg(hpc_pkg::REG_MAX_R, hi_r);
    endtask

    initial
    begin
        int lo_q, lo_r;
        rst_n = 1'b0;
        point_ch.valid = 1'b0;
        point_ch.pos_x = '0;
        point_ch.pos_y = '0;
        cell_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 25;
        recv_idle_pct = 66;

        // Reset settings: extremes of both coordinates, saturating cells
        add_point(32'sd0, 32'sd0);
        add_point(32'sh7fff_ffff, 32'sh7fff_ffff);
        add_point(32'sh8000_0000, 32'sh8000_0000);
        add_point(32'sh7fff_ffff, 32'sh8000_0000);
        add_point(32'sh8000_0000, 32'sh7fff_ffff);
        add_point(-32'sd1, -32'sd1);
        add_point(32'sd1, 32'sd1);
        drain();

        // Unit reciprocals: half-unit points give exact rounding ties
        set_reg(hpc_pkg::REG_X_RECIP, RECIP_ONE);
        set_reg(hpc_pkg::REG_Y_RECIP, RECIP_ONE);
        set_reg(REG_SPARE_INDEX, 32'h0000_0001);
        settle_config();
        add_point(32'sh0000_8000, 32'sd0);
        add_point(-32'sh0000_8000, 32'sd0);
        add_point(32'sd0, 32'sh0000_8000);
        add_point(32'sd0, -32'sh0000_8000);
        add_point(32'sh0000_8000, 32'sh0000_8000);
        drain();

        // Bounded window, pointy: inside, outside on each axis, saturated outside
        set_reg(hpc_pkg::REG_ORIENTATION, 32'(hpc_pkg::ORIENT_POINTY));
        set_reg(hpc_pkg::REG_BOUNDED, 32'd1);
        set_limits(-2, -2, 2, 2);
        settle_config();
        add_point(32'sd0, 32'sd0);
        add_point(32'sh0005_0000, 32'sd0);
        add_point(32'sd0, -32'sh0005_0000);
        add_point(32'sh8000_0000, 32'sh8000_0000);
        drain();

        // Empty window: min above max
        set_reg(hpc_pkg::REG_MIN_Q, 3);
        set_reg(hpc_pkg::REG_MAX_Q, -3);
        settle_config();
        add_point(32'sd0, 32'sd0);
        add_point(32'sh0001_0000, 32'sd0);
        drain();

        // Flat, default reciprocals, unbounded
        set_reg(hpc_pkg::REG_ORIENTATION, 32'(hpc_pkg::ORIENT_FLAT));
        set_reg(hpc_pkg::REG_X_RECIP, hpc_pkg::X_RECIP_RESET);
        set_reg(hpc_pkg::REG_Y_RECIP, hpc_pkg::Y_RECIP_RESET);
        set_reg(hpc_pkg::REG_BOUNDED, 32'd0);
        settle_config();
        add_random(160);
        drain();

        // Pointy, bounded; hold the sender midway until all cells are back
        set_reg(hpc_pkg::REG_ORIENTATION, 32'(hpc_pkg::ORIENT_POINTY));
        set_reg(hpc_pkg::REG_X_RECIP, RECIP_ONE);
        set_reg(hpc_pkg::REG_Y_RECIP, hpc_pkg::X_RECIP_RESET);
        set_reg(hpc_pkg::REG_BOUNDED, 32'd1);
        set_limits(-20, -15, 20, 25);
        settle_config();
        add_random(80);
        drain();
        add_random(80);
        drain();

        send_idle_pct = 66;
        recv_idle_pct = 25;

        // Largest reciprocals, full 16-bit window
        set_reg(hpc_pkg::REG_ORIENTATION, 32'(hpc_pkg::ORIENT_FLAT));
        set_reg(hpc_pkg::REG_X_RECIP, 32'hffff_ffff);
        set_reg(hpc_pkg::REG_Y_RECIP, 32'hffff_ffff);
        set_limits(-32768, -32768, 32767, 32767);
        settle_config();
        add_random(160);
        drain();

        // Zero reciprocals, unbounded
        set_reg(hpc_pkg::REG_ORIENTATION, 32'(hpc_pkg::ORIENT_POINTY));
        set_reg(hpc_pkg::REG_X_RECIP, 32'd0);
        set_reg(hpc_pkg::REG_Y_RECIP, 32'd0);
        set_reg(hpc_pkg::REG_BOUNDED, 32'd0);
        settle_config();
        add_random(60);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Unit reciprocals with random points, tight window
        set_reg(hpc_pkg::REG_ORIENTATION, 32'(hpc_pkg::ORIENT_FLAT));
        set_reg(hpc_pkg::REG_X_RECIP, RECIP_ONE);
        set_reg(hpc_pkg::REG_Y_RECIP, RECIP_ONE);
        set_reg(hpc_pkg::REG_BOUNDED, 32'd1);
        set_limits(-5, -5, 5, 5);
        settle_config();
        add_random(160);
        drain();

        // Pointy, random reciprocals and a random window
        lo_q = int'($urandom_range(100)) - 50;
        lo_r = int'($urandom_range(100)) - 50;
        set_reg(hpc_pkg::REG_ORIENTATION, 32'(hpc_pkg::ORIENT_POINTY));
        set_reg(hpc_pkg::REG_X_RECIP, $urandom_range(32'h0400_0000, 32'h0010_0000));
        set_reg(hpc_pkg::REG_Y_RECIP, $urandom_range(32'h0400_0000, 32'h0010_0000));
        set_limits(lo_q, lo_r, lo_q + int'($urandom_range(100)),
                   lo_r + int'($urandom_range(100)));
        settle_config();
        add_random(160);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d cells for %0d points after %0d register writes",
                 cells_checked, points_accepted, reg_writes_done);
        $display("%0d cells outside the window, %0d with a saturated coordinate",
                 outside_count, saturated_count);
        if (mismatch_count == 0 && expected_cells.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
